@@ rtl/sep_pkg.sv @@
package sep_pkg;

  localparam int STACK_DEPTH_DEF   = 256;
  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int TIME_BITS_DEF     = 48;
  localparam int SITE_BITS_DEF     = 16;

  localparam int IN_SITE_W  = 16;
  localparam int IN_TIME_W  = 48;
  localparam int OUT_SITE_W = 16;
  localparam int OUT_CALL_W = 32;
  localparam int OUT_TOT_W  = 48;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_END   = 2'd1,
    KIND_FLUSH = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVERFLOW  = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_FULL      = 3'd3,
    ST_RECORD    = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RESP,
    S_END_POP,
    S_SRCH_RD,
    S_SRCH_CK,
    S_NEW,
    S_FL_RD,
    S_FL_CK,
    S_FL_OUT
  } state_t;

endpackage

@@ rtl/sep_ram.sv @@
module sep_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/scope_event_profiler_top.sv @@
// Scope profiler. Each beat on the input is a scope start, a scope end or a frame
// flush (tuser). Starts push onto an open-scope stack held in RAM; an end pops it
// and walks the site table one entry at a time, a read and a check state per
// entry, through the table RAM read port, then adds the elapsed ticks and one
// call to the matching entry with saturation, or appends a new entry. A flush
// emits the table in ascending order of total, ties in creation order, by
// repeated min-search passes over the table RAM. The input is not ready while an
// item is in work; a result waits in the output register while the next item is
// accepted.
module scope_event_profiler_top #(
  parameter int STACK_DEPTH   = sep_pkg::STACK_DEPTH_DEF,
  parameter int TABLE_ENTRIES = sep_pkg::TABLE_ENTRIES_DEF,
  parameter int TIME_BITS     = sep_pkg::TIME_BITS_DEF,
  parameter int SITE_BITS     = sep_pkg::SITE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // site_id[15:0], timestamp[63:16]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // record_site[15:0], record_calls[47:16], record_total[95:48]
  output logic [2:0]  m_tuser,   // status[2:0]
  output logic        m_tlast
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int LW  = $clog2(STACK_DEPTH + 1);
  localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW  = $clog2(TABLE_ENTRIES + 1);
  localparam int CLW = sep_pkg::OUT_CALL_W;
  localparam int EW  = SITE_BITS + CLW + TIME_BITS;
  localparam int SW  = SITE_BITS + TIME_BITS;

  sep_pkg::state_t state, state_next;

  logic [TIME_BITS-1:0] stamp;
  logic [LW-1:0]        level, level_next;
  logic [CW-1:0]        count, count_next;
  logic [IW-1:0]        idx, idx_next;
  logic [CW-1:0]        pos, pos_next;
  logic [SITE_BITS-1:0] pop_site, pop_site_next;
  logic [TIME_BITS-1:0] dur, dur_next;
  logic [2:0]           resp, resp_next;
  logic                 found, found_next;
  logic [IW-1:0]        best_idx, best_idx_next;
  logic [TIME_BITS-1:0] best_total, best_total_next;
  logic [TABLE_ENTRIES-1:0] emitted, emitted_next;

  logic           stk_we;
  logic [SAW-1:0] stk_waddr, stk_raddr;
  logic [SW-1:0]  stk_wdata, stk_rdata;
  logic           tab_we;
  logic [IW-1:0]  tab_waddr;
  logic [EW-1:0]  tab_wdata, tab_rdata;

  logic [SITE_BITS-1:0] e_site;
  logic [CLW-1:0]       e_calls;
  logic [TIME_BITS-1:0] e_total;
  logic [TIME_BITS:0]   acc_sum;
  logic                 out_free;
  logic                 out_load;
  logic [2:0]           out_status;
  logic                 out_last;
  logic                 out_rec;
  logic                 fl_ready;

  sep_ram #(.WIDTH(SW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rdata)
  );

  sep_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
    .clk(clk), .we(tab_we), .waddr(tab_waddr), .wdata(tab_wdata),
    .raddr(idx), .rdata(tab_rdata)
  );

  assign e_site   = tab_rdata[SITE_BITS-1:0];
  assign e_calls  = tab_rdata[SITE_BITS +: CLW];
  assign e_total  = tab_rdata[SITE_BITS+CLW +: TIME_BITS];
  assign acc_sum  = {1'b0, e_total} + {1'b0, dur};
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == sep_pkg::S_IDLE);

  assign stk_waddr = level[SAW-1:0];
  assign stk_wdata = {TIME_BITS'(s_tdata[63:16]), SITE_BITS'(s_tdata[15:0])};
  assign stk_raddr = SAW'(level - LW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sep_pkg::S_IDLE;
      level   <= '0;
      count   <= '0;
      emitted <= '0;
    end else begin
      state   <= state_next;
      level   <= level_next;
      count   <= count_next;
      emitted <= emitted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stamp <= TIME_BITS'(s_tdata[63:16]);
    end
    idx        <= idx_next;
    pos        <= pos_next;
    pop_site   <= pop_site_next;
    dur        <= dur_next;
    resp       <= resp_next;
    found      <= found_next;
    best_idx   <= best_idx_next;
    best_total <= best_total_next;
  end

  always_comb begin
    state_next      = state;
    level_next      = level;
    count_next      = count;
    emitted_next    = emitted;
    idx_next        = idx;
    pos_next        = pos;
    pop_site_next   = pop_site;
    dur_next        = dur;
    resp_next       = resp;
    found_next      = found;
    best_idx_next   = best_idx;
    best_total_next = best_total;
    stk_we          = 1'b0;
    tab_we          = 1'b0;
    tab_waddr       = idx;
    tab_wdata       = tab_rdata;
    out_load        = 1'b0;
    out_status      = resp;
    out_last        = 1'b1;
    out_rec         = 1'b0;
    unique case (state)
      sep_pkg::S_IDLE: begin
        if (s_tvalid) begin
          resp_next  = sep_pkg::ST_OK;
          state_next = sep_pkg::S_RESP;
          unique case (s_tuser)
            sep_pkg::KIND_START: begin
              if (level == LW'(STACK_DEPTH)) begin
                resp_next = sep_pkg::ST_OVERFLOW;
              end else begin
                stk_we     = 1'b1;
                level_next = level + LW'(1);
              end
            end
            sep_pkg::KIND_END: begin
              if (level == '0) begin
                resp_next = sep_pkg::ST_UNDERFLOW;
              end else begin
                level_next = level - LW'(1);
                state_next = sep_pkg::S_END_POP;
              end
            end
            sep_pkg::KIND_FLUSH: begin
              level_next = '0;
              if (count == '0) begin
                resp_next = sep_pkg::ST_EMPTY;
              end else begin
                emitted_next = '0;
                pos_next     = '0;
                idx_next     = '0;
                found_next   = 1'b0;
                state_next   = sep_pkg::S_FL_RD;
              end
            end
            default: ;
          endcase
        end
      end
      sep_pkg::S_RESP: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = sep_pkg::S_IDLE;
        end
      end
      sep_pkg::S_END_POP: begin
        pop_site_next = stk_rdata[SITE_BITS-1:0];
        dur_next      = stamp - stk_rdata[SITE_BITS +: TIME_BITS];
        idx_next      = '0;
        state_next    = (count == '0) ? sep_pkg::S_NEW : sep_pkg::S_SRCH_RD;
      end
      sep_pkg::S_SRCH_RD: begin
        state_next = sep_pkg::S_SRCH_CK;
      end
      sep_pkg::S_SRCH_CK: begin
        if (e_site == pop_site) begin
          tab_we    = 1'b1;
          tab_wdata = {acc_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : acc_sum[TIME_BITS-1:0],
                       (&e_calls) ? e_calls : e_calls + CLW'(1), e_site};
          resp_next  = sep_pkg::ST_OK;
          state_next = sep_pkg::S_RESP;
        end else if (CW'(idx) + CW'(1) == count) begin
          state_next = sep_pkg::S_NEW;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = sep_pkg::S_SRCH_RD;
        end
      end
      sep_pkg::S_NEW: begin
        state_next = sep_pkg::S_RESP;
        if (count == CW'(TABLE_ENTRIES)) begin
          resp_next = sep_pkg::ST_FULL;
        end else begin
          tab_we     = 1'b1;
          tab_waddr  = IW'(count);
          tab_wdata  = {dur, CLW'(1), pop_site};
          count_next = count + CW'(1);
          resp_next  = sep_pkg::ST_OK;
        end
      end
      sep_pkg::S_FL_RD: begin
        state_next = sep_pkg::S_FL_CK;
      end
      sep_pkg::S_FL_CK: begin
        // Strict compare keeps the earliest entry among equal totals.
        if (!emitted[idx] && (!found || e_total < best_total)) begin
          found_next      = 1'b1;
          best_idx_next   = idx;
          best_total_next = e_total;
        end
        if (CW'(idx) + CW'(1) == count) begin
          idx_next   = best_idx_next;
          state_next = sep_pkg::S_FL_OUT;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = sep_pkg::S_FL_RD;
        end
      end
      sep_pkg::S_FL_OUT: begin
        // The table is reading best_idx again, so its record is on rdata once
        // fl_ready is set.
        out_status = sep_pkg::ST_RECORD;
        out_rec    = 1'b1;
        out_last   = (pos + CW'(1) == count);
        if (out_free && fl_ready) begin
          out_load               = 1'b1;
          emitted_next[best_idx] = 1'b1;
          pos_next               = pos + CW'(1);
          idx_next               = '0;
          found_next             = 1'b0;
          if (out_last) begin
            count_next = '0;
            state_next = sep_pkg::S_IDLE;
          end else begin
            state_next = sep_pkg::S_FL_RD;
          end
        end
      end
      default: state_next = sep_pkg::S_IDLE;
    endcase
  end

  // fl_ready marks that the table RAM's registered read of best_idx is on rdata.
  always_ff @(posedge clk) begin
    if (rst) begin
      fl_ready <= 1'b0;
    end else begin
      fl_ready <= (state == sep_pkg::S_FL_OUT);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load && (!out_rec || fl_ready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && (!out_rec || fl_ready)) begin
      m_tuser <= out_status;
      m_tlast <= out_last;
      if (out_rec) begin
        m_tdata <= {sep_pkg::OUT_TOT_W'(e_total), sep_pkg::OUT_CALL_W'(e_calls),
                    sep_pkg::OUT_SITE_W'(e_site)};
      end else begin
        m_tdata <= '0;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) level <= LW'(STACK_DEPTH))
    else $error("stack level beyond depth");
  assert property (@(posedge clk) disable iff (rst) count <= CW'(TABLE_ENTRIES))
    else $error("entry count beyond table size");
  assert property (@(posedge clk) disable iff (rst)
    (state == sep_pkg::S_FL_RD || state == sep_pkg::S_FL_CK)
      |-> ($countones(emitted) == int'(pos)))
    else $error("emitted marks out of step with records sent");
  assert property (@(posedge clk) disable iff (rst)
    (state == sep_pkg::S_FL_OUT) |-> !emitted[best_idx])
    else $error("record chosen twice in one flush");

endmodule

@@ dv/scope_event_profiler_top_test.sv @@
`timescale 1ns / 1ps

module scope_event_profiler_top_test;
  import sep_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int ENTRIES = TABLE_ENTRIES_DEF;
  localparam logic [47:0] TICK_MAX = '1;
  localparam logic [31:0] CALL_MAX = '1;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    kind_t       kind;
    logic [15:0] site;
    logic [47:0] ts;
    bit          drain;
  } event_t;

  typedef struct {
    status_t     status;
    logic [15:0] site;
    logic [31:0] calls;
    logic [47:0] total;
    logic        last;
  } record_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;

  scope_event_profiler_top dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  event_t  pending_events[$];
  record_t expected_records[$];
  int      errors = 0;
  int      total_events = 0;
  int      events_sent = 0;
  int      results_seen = 0;
  int      status_seen[8];
  int      cycles = 0;
  int      hold_cycles = 0;
  bit      hold_done = 0;

  // Shadow of the profiler state.
  logic [15:0] open_site[DEPTH];
  logic [47:0] open_time[DEPTH];
  int          open_level = 0;
  logic [15:0] tab_site[ENTRIES];
  logic [31:0] tab_calls[ENTRIES];
  logic [47:0] tab_total[ENTRIES];
  int          tab_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic push_record(status_t st, logic [15:0] site, logic [31:0] calls,
                             logic [47:0] total, logic last);
    record_t r;
    r.status = st;
    r.site = site;
    r.calls = calls;
    r.total = total;
    r.last = last;
    expected_records.push_back(r);
  endtask

  function automatic status_t close_scope(logic [47:0] now);
    logic [15:0] site;
    logic [47:0] d;
    if (open_level == 0) return ST_UNDERFLOW;
    open_level--;
    site = open_site[open_level];
    d = now - open_time[open_level];
    for (int i = 0; i < tab_count; i++) begin
      if (tab_site[i] == site) begin
        if (tab_calls[i] != CALL_MAX) tab_calls[i]++;
        if (tab_total[i] > TICK_MAX - d) tab_total[i] = TICK_MAX;
        else tab_total[i] += d;
        return ST_OK;
      end
    end
    if (tab_count >= ENTRIES) return ST_FULL;
    tab_site[tab_count] = site;
    tab_calls[tab_count] = 1;
    tab_total[tab_count] = d;
    tab_count++;
    return ST_OK;
  endfunction

  task automatic predict_profile(event_t ev);
    int order[ENTRIES];
    int j, t;
    case (ev.kind)
      KIND_START: begin
        if (open_level >= DEPTH) begin
          push_record(ST_OVERFLOW, 0, 0, 0, 1);
        end else begin
          open_site[open_level] = ev.site;
          open_time[open_level] = ev.ts;
          open_level++;
          push_record(ST_OK, 0, 0, 0, 1);
        end
      end
      KIND_END: push_record(close_scope(ev.ts), 0, 0, 0, 1);
      KIND_FLUSH: begin
        if (tab_count == 0) begin
          push_record(ST_EMPTY, 0, 0, 0, 1);
        end else begin
          // Stable insertion sort keeps ties in creation order.
          for (int i = 0; i < tab_count; i++) order[i] = i;
          for (int i = 1; i < tab_count; i++) begin
            t = order[i];
            j = i;
            while (j > 0 && tab_total[t] < tab_total[order[j-1]]) begin
              order[j] = order[j-1];
              j--;
            end
            order[j] = t;
          end
          for (int i = 0; i < tab_count; i++)
            push_record(ST_RECORD, tab_site[order[i]], tab_calls[order[i]],
                        tab_total[order[i]], i == tab_count - 1);
        end
        open_level = 0;
        tab_count = 0;
      end
      default: push_record(ST_OK, 0, 0, 0, 1);
    endcase
  endtask

  task automatic report(string field, logic [63:0] got, logic [63:0] want);
    errors++;
    $display("tb: mismatch on %s at result %0d: got %0h, expected %0h",
             field, results_seen, got, want);
  endtask

  task automatic add_event(kind_t kind, logic [15:0] site, logic [47:0] ts, bit drain = 0);
    event_t ev;
    ev.kind = kind;
    ev.site = site;
    ev.ts = ts;
    ev.drain = drain;
    pending_events.push_back(ev);
  endtask

  function automatic logic [47:0] rand_ts();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic int idle_percent(bit receiver);
    if (events_sent < total_events / 3) return receiver ? 83 : 38;
    if (events_sent < 2 * total_events / 3) return receiver ? 38 : 83;
    return 0;
  endfunction

  // Driver: offers the pending events, predicting each one as it is accepted.
  always @(posedge clk) begin
    event_t ev;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        ev.kind = kind_t'(s_tuser);
        ev.site = s_tdata[15:0];
        ev.ts = s_tdata[63:16];
        predict_profile(ev);
        events_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_events.size() > 0 &&
            (!pending_events[0].drain || expected_records.size() == 0) &&
            $urandom_range(99) >= idle_percent(0)) begin
          ev = pending_events.pop_front();
          s_tdata <= {ev.ts, ev.site};
          s_tuser <= ev.kind;
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls at random and checks every result beat against the oldest expectation.
  always @(posedge clk) begin
    record_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_records.size() == 0) begin
          report("unexpected beat status", 64'(m_tuser), 64'd0);
        end else begin
          want = expected_records.pop_front();
          if (m_tuser != want.status) report("status", m_tuser, want.status);
          if (m_tdata[15:0] != want.site) report("record_site", m_tdata[15:0], want.site);
          if (m_tdata[47:16] != want.calls) report("record_calls", m_tdata[47:16], want.calls);
          if (m_tdata[95:48] != want.total) report("record_total", m_tdata[95:48], want.total);
          if (m_tlast != want.last) report("last", m_tlast, want.last);
        end
        if (m_tuser < 8) status_seen[m_tuser]++;
        results_seen++;
      end
      // One long hold-off lets the block back up into its input.
      if (!hold_done && results_seen >= 40) begin
        hold_done <= 1;
        hold_cycles <= 400;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
      end
      m_tready <= (hold_cycles == 0) && ($urandom_range(99) >= idle_percent(1));
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    logic [15:0] pool[48];
    logic [47:0] now;
    int open_cnt, steps, random_count;

    // Directed: underflow, ignored kind, empty flush.
    add_event(KIND_END, 16'h1234, rand_ts());
    add_event(KIND_NONE, 16'hffff, TICK_MAX);
    add_event(KIND_FLUSH, 0, 0);
    // Elapsed time that wraps, the largest duration, and a saturating total.
    add_event(KIND_START, 16'h0000, TICK_MAX);
    add_event(KIND_END, 16'hffff, 48'd5);
    add_event(KIND_START, 16'hffff, 48'd0);
    add_event(KIND_END, 16'h0000, TICK_MAX);
    add_event(KIND_START, 16'hffff, 48'd100);
    add_event(KIND_END, 16'h5555, 48'd110);
    // Two sites with equal totals keep their creation order.
    add_event(KIND_START, 16'haaaa, 48'd1000);
    add_event(KIND_START, 16'h5555, 48'd1002);
    add_event(KIND_END, 16'h0, 48'd1008);
    add_event(KIND_END, 16'h0, 48'd1006);
    add_event(KIND_FLUSH, 16'hffff, rand_ts());
    // Stack overflow, then a flush that also clears the stack.
    for (int i = 0; i <= DEPTH; i++) add_event(KIND_START, 16'(i), 48'(i), i == 0);
    add_event(KIND_FLUSH, 0, 0);
    add_event(KIND_END, 0, 0);
    // Table full: one more new site than there are entries.
    for (int i = 0; i <= ENTRIES; i++) begin
      add_event(KIND_START, 16'(16'h100 + i), 48'd50, i == 0);
      add_event(KIND_END, 0, 48'd50 + 48'((i * 7) % 11));
    end
    add_event(KIND_START, 16'h100, 48'd0);
    add_event(KIND_END, 0, 48'd3);
    add_event(KIND_FLUSH, 0, 0);

    // Random: mostly well-formed frames over a pool of sites, some noise.
    foreach (pool[i]) pool[i] = 16'($urandom);
    random_count = 0;
    while (random_count < 40) begin
      if ($urandom_range(99) < 85) begin
        now = rand_ts();
        open_cnt = 0;
        steps = $urandom_range(4, 24);
        for (int k = 0; k < steps; k++) begin
          now += $urandom_range(0, 3) == 0 ? rand_ts() : 48'($urandom_range(1, 5000));
          if (open_cnt == 0 || ($urandom_range(1) == 1 && open_cnt < 8)) begin
            add_event(KIND_START, pool[$urandom_range(47)], now);
            open_cnt++;
          end else begin
            add_event(KIND_END, 16'($urandom), now);
            open_cnt--;
          end
          random_count++;
        end
        if ($urandom_range(3) != 0) begin
          while (open_cnt > 0) begin
            now += 48'($urandom_range(1, 900));
            add_event(KIND_END, 16'($urandom), now);
            open_cnt--;
            random_count++;
          end
        end
        add_event(KIND_FLUSH, 16'($urandom), rand_ts(), $urandom_range(9) == 0);
        random_count++;
      end else begin
        add_event(kind_t'($urandom_range(3)), 16'($urandom), rand_ts());
        random_count++;
      end
    end
    total_events = pending_events.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending_events.size() > 0 || s_tvalid || expected_records.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);

    $display("tb: %0d events driven, %0d result beats checked, %0d table records",
             events_sent, results_seen, status_seen[ST_RECORD]);
    $display("tb: overflow %0d, underflow %0d, table full %0d, empty flush %0d",
             status_seen[ST_OVERFLOW], status_seen[ST_UNDERFLOW],
             status_seen[ST_FULL], status_seen[ST_EMPTY]);
    if (errors == 0 && expected_records.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
